### rtl/core/amps_pkg.sv
// ----------------------------------------------------------------------------
// amps_pkg : shared types and constants for the arc successor core
// Fixed-point formats, CORDIC angle table, stage map and register codes.
// ----------------------------------------------------------------------------
package amps_pkg;

    // number formats
    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 18;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                  : ATAN_ENTRIES;
    localparam int ANG_W   = 19;
    localparam int CFG_W   = 24;
    localparam int POS_W   = 32;
    localparam int PRIM_W  = 4;
    localparam int TC_W    = 2;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_RADIUS = 2'd1;
    localparam logic [CFG_W-1:0]     STEP_RESET      = 24'd65536;
    localparam logic [CFG_W-1:0]     RAD_RESET       = 24'd327680;

    // turn and climb classes
    localparam logic [TC_W-1:0] TC_NEG      = 2'd0;
    localparam logic [TC_W-1:0] TC_STRAIGHT = 2'd1;
    localparam logic [TC_W-1:0] TC_POS      = 2'd2;
    localparam logic [TC_W-1:0] CC_DOWN     = 2'd0;
    localparam logic [TC_W-1:0] CC_LEVEL    = 2'd1;
    localparam logic [TC_W-1:0] CC_UP       = 2'd2;
    localparam logic [PRIM_W-1:0] PRIM_MAX  = 4'd8;

    // 2pi in heading format, rounded from a Q32 value
    localparam longint unsigned TWO_PI_Q32 = 64'd26986075409;
    localparam logic [ANG_W-1:0] TWO_PI_Q =
        ANG_W'((TWO_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

    // CORDIC datapath, Q30
    localparam int Z_W  = 35;
    localparam int XY_W = 33;
    localparam logic signed [Z_W-1:0]  PI_Q30      = 35'sd3373259426;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [Z_W-1:0]  TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [XY_W-1:0] GAIN_Q30    = 33'sd652032874;

    // move, square and root widths
    localparam int D_W      = 28;
    localparam int MUL_W    = CFG_W + 1 + Z_W;
    localparam int SUM_W    = 2 * D_W;
    localparam int SQ_STEPS = SUM_W / 2;
    localparam int ROOT_W   = SQ_STEPS + 1;

    // turn-rate divider and climb step
    localparam int DIV_W   = CFG_W + FRAC_BITS;
    localparam int CNT_W   = $clog2(DIV_W + 1);
    localparam int DZ_W    = 22;
    localparam int DZSQ_W  = 2 * DZ_W;
    localparam logic [3:0] CLIMB_BIAS = 4'd3;
    // floor(n / 6) = (n * ceil(2^28 / 6)) >> 28, exact for n below 2^27
    localparam int RECIP6_W    = 26;
    localparam int CLIMB_SHIFT = 28;
    localparam logic [RECIP6_W-1:0] CLIMB_RECIP = 26'd44739243;

    // stage map
    localparam int ST_PREP       = 0;
    localparam int ST_FOLD       = 1;
    localparam int ST_CORDIC_END = ST_FOLD + CORDIC_N;
    localparam int ST_SEL        = ST_CORDIC_END + 1;
    localparam int ST_MUL        = ST_SEL + 1;
    localparam int ST_RND        = ST_MUL + 1;
    localparam int ST_SQ         = ST_RND + 1;
    localparam int ST_SUM        = ST_SQ + 1;
    localparam int ST_SQRT_END   = ST_SUM + SQ_STEPS;
    localparam int ST_OUT        = ST_SQRT_END + 1;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [POS_W-1:0]        cost;
        logic [TC_W-1:0]         tc;
        logic [TC_W-1:0]         cc;
        logic [ANG_W-1:0]        nt;
        logic                    straight;
    } side_t;

    typedef struct packed {
        logic signed [Z_W-1:0] z;
        logic                  flip;
    } fold_t;

    function automatic logic signed [Z_W-1:0] atan_q30(input int k);
        logic signed [Z_W-1:0] a;
        case (k)
            0:  a = 35'sh03243F6A8;
            1:  a = 35'sh01DAC6705;
            2:  a = 35'sh00FADBAFC;
            3:  a = 35'sh007F56EA6;
            4:  a = 35'sh003FEAB76;
            5:  a = 35'sh001FFD55B;
            6:  a = 35'sh000FFFAAA;
            7:  a = 35'sh0007FFF55;
            8:  a = 35'sh0003FFFEA;
            9:  a = 35'sh0001FFFFD;
            10: a = 35'sh0000FFFFF;
            11: a = 35'sh00007FFFF;
            12: a = 35'sh00003FFFF;
            13: a = 35'sh00001FFFF;
            14: a = 35'sh00000FFFF;
            15: a = 35'sh000007FFF;
            16: a = 35'sh000003FFF;
            17: a = 35'sh000001FFF;
            18: a = 35'sh000000FFF;
            19: a = 35'sh0000007FF;
            20: a = 35'sh0000003FF;
            21: a = 35'sh0000001FF;
            22: a = 35'sh0000000FF;
            23: a = 35'sh00000007F;
            default: a = '0;
        endcase
        return a;
    endfunction

    // angle in [0, 2pi) to Q30 in [-pi/2, pi/2]; flip negates sin and cos
    function automatic fold_t fold_angle(input logic [ANG_W-1:0] ang);
        fold_t                 f;
        logic signed [Z_W-1:0] z;
        z = $signed(Z_W'(ang) << (30 - FRAC_BITS));
        if (z > PI_Q30) begin
            z = z - TWO_PI_Q30;
        end
        f.flip = 1'b0;
        if (z > HALF_PI_Q30) begin
            z      = z - PI_Q30;
            f.flip = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            z      = z + PI_Q30;
            f.flip = 1'b1;
        end
        f.z = z;
        return f;
    endfunction

endpackage

### rtl/core/arc_motion_primitive_successor_core.sv
// ----------------------------------------------------------------------------
// arc_motion_primitive_successor_core : constant-turn-rate successor generator
// Expands one search node along one of nine motion primitives per word.
// ----------------------------------------------------------------------------
// One input word (position, heading, cost, primitive 0..8) gives one result
// word. A new word is taken every cycle while the result side keeps up and the
// core is not busy; the whole pipeline advances as one, so it holds when a
// result waits and its last stage is full. After reset and after every
// configuration write the core derives turn rate, its value modulo 2pi and the
// climb step from the registers; s_ready and cfg_ready are low meanwhile.
// The length of this busy window is set by the bit-serial turn-rate divider.
// ----------------------------------------------------------------------------
module arc_motion_primitive_successor_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [amps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [amps_pkg::CFG_W-1:0]            cfg_data,
    // input words
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [amps_pkg::POS_W-1:0]     s_pos_x,
    input  logic signed [amps_pkg::POS_W-1:0]     s_pos_y,
    input  logic signed [amps_pkg::POS_W-1:0]     s_pos_z,
    input  logic [amps_pkg::ANG_W-1:0]            s_heading,
    input  logic [amps_pkg::POS_W-1:0]            s_cost_so_far,
    input  logic [amps_pkg::PRIM_W-1:0]           s_primitive_req,
    // result words
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [amps_pkg::POS_W-1:0]     m_next_x,
    output logic signed [amps_pkg::POS_W-1:0]     m_next_y,
    output logic signed [amps_pkg::POS_W-1:0]     m_next_z,
    output logic [amps_pkg::ANG_W-1:0]            m_next_heading,
    output logic [amps_pkg::POS_W-1:0]            m_next_cost,
    output logic [amps_pkg::TC_W-1:0]             m_turn_class
);

    // ------------------------------------------------------------------
    // Configuration and derived constants
    // ------------------------------------------------------------------
    logic [amps_pkg::CFG_W-1:0]  step_reg, rad_reg;
    logic                        busy_reg;
    logic [amps_pkg::CNT_W-1:0]  cnt_reg;
    logic [amps_pkg::CFG_W-1:0]  rem_reg, rem_next;
    logic [amps_pkg::ANG_W-1:0]  wm_reg, wm_next;     // turn rate mod 2pi
    logic                        w0nz_reg, w0nz_next; // turn rate non-zero
    logic [amps_pkg::DZ_W-1:0]   dzq_reg;             // climb step
    logic [amps_pkg::DZSQ_W-1:0] dzsq_reg;

    logic [amps_pkg::CFG_W-1:0]  rad_eff;
    logic [amps_pkg::DIV_W-1:0]  dividend;
    logic [amps_pkg::CNT_W-1:0]  bit_idx;
    logic                        div_bit, qbit;
    logic [amps_pkg::CFG_W:0]    rem_t;
    logic [amps_pkg::ANG_W:0]    wm_t;
    logic                        cfg_acc;
    logic [amps_pkg::CFG_W:0]    num6;
    logic [amps_pkg::CFG_W+amps_pkg::RECIP6_W:0] prod6;

    assign cfg_ready = !busy_reg;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign rad_eff   = (rad_reg == '0) ? amps_pkg::CFG_W'(1) : rad_reg;

    // climb step (step + 3) / 6 by reciprocal multiply
    assign num6  = (amps_pkg::CFG_W+1)'(step_reg) + (amps_pkg::CFG_W+1)'(amps_pkg::CLIMB_BIAS);
    assign prod6 = (amps_pkg::CFG_W+amps_pkg::RECIP6_W+1)'(num6)
                 * (amps_pkg::CFG_W+amps_pkg::RECIP6_W+1)'(amps_pkg::CLIMB_RECIP);

    // one quotient bit per cycle, MSB first; each bit also feeds the 2pi
    // reduction so w0 mod 2pi falls out with the quotient
    always_comb begin
        dividend = {step_reg, {amps_pkg::FRAC_BITS{1'b0}}};
        bit_idx  = amps_pkg::CNT_W'(amps_pkg::DIV_W - 1) - cnt_reg;
        div_bit  = dividend[bit_idx];

        rem_t = {rem_reg, div_bit};
        if (rem_t >= {1'b0, rad_eff}) begin
            rem_next = amps_pkg::CFG_W'(rem_t - {1'b0, rad_eff});
            qbit     = 1'b1;
        end else begin
            rem_next = rem_t[amps_pkg::CFG_W-1:0];
            qbit     = 1'b0;
        end

        wm_t = {wm_reg, qbit};
        if (wm_t >= {1'b0, amps_pkg::TWO_PI_Q}) begin
            wm_next = amps_pkg::ANG_W'(wm_t - {1'b0, amps_pkg::TWO_PI_Q});
        end else begin
            wm_next = wm_t[amps_pkg::ANG_W-1:0];
        end
        w0nz_next = w0nz_reg | qbit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= amps_pkg::STEP_RESET;
            rad_reg  <= amps_pkg::RAD_RESET;
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            wm_reg   <= '0;
            w0nz_reg <= 1'b0;
        end else if (cfg_acc) begin
            case (cfg_index)
                amps_pkg::REG_STEP_LENGTH: step_reg <= cfg_data;
                amps_pkg::REG_TURN_RADIUS: rad_reg  <= cfg_data;
                default: ;
            endcase
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            wm_reg   <= '0;
            w0nz_reg <= 1'b0;
        end else if (busy_reg) begin
            if (cnt_reg != amps_pkg::CNT_W'(amps_pkg::DIV_W)) begin
                rem_reg  <= rem_next;
                wm_reg   <= wm_next;
                w0nz_reg <= w0nz_next;
                cnt_reg  <= cnt_reg + 1'b1;
            end else begin
                busy_reg <= 1'b0;
            end
        end
    end

    // climb step and its square are registered in turn after a step write and settle well inside the busy window
    always_ff @(posedge aclk) begin
        dzq_reg  <= prod6[amps_pkg::CLIMB_SHIFT +: amps_pkg::DZ_W];
        dzsq_reg <= dzq_reg * dzq_reg;
    end

    // ------------------------------------------------------------------
    // Pipeline control: one enable for every stage
    // ------------------------------------------------------------------
    logic                 v_reg [0:amps_pkg::ST_OUT];
    amps_pkg::side_t      sb_reg [0:amps_pkg::ST_OUT];
    amps_pkg::side_t      sb_in;
    logic                 en;

    assign en      = m_ready || !v_reg[amps_pkg::ST_OUT];
    assign s_ready = en && !busy_reg;
    assign m_valid = v_reg[amps_pkg::ST_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= amps_pkg::ST_OUT; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= s_valid && s_ready;
            for (int i = 1; i <= amps_pkg::ST_OUT; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: heading range, primitive decode, new heading
    // ------------------------------------------------------------------
    logic [amps_pkg::ANG_W-1:0]  th_c, th_reg;
    logic [amps_pkg::PRIM_W-1:0] prim_c;
    logic [amps_pkg::TC_W-1:0]   tc_c, cc_c;
    logic [amps_pkg::ANG_W:0]    nt_sum;
    logic                        straight_c;

    always_comb begin
        th_c = (s_heading >= amps_pkg::TWO_PI_Q) ? s_heading - amps_pkg::TWO_PI_Q
                                                 : s_heading;
        prim_c = (s_primitive_req > amps_pkg::PRIM_MAX) ? amps_pkg::PRIM_MAX
                                                        : s_primitive_req;
        unique case (prim_c)
            4'd0: begin tc_c = amps_pkg::TC_NEG;      cc_c = amps_pkg::CC_DOWN;  end
            4'd1: begin tc_c = amps_pkg::TC_NEG;      cc_c = amps_pkg::CC_LEVEL; end
            4'd2: begin tc_c = amps_pkg::TC_NEG;      cc_c = amps_pkg::CC_UP;    end
            4'd3: begin tc_c = amps_pkg::TC_STRAIGHT; cc_c = amps_pkg::CC_DOWN;  end
            4'd4: begin tc_c = amps_pkg::TC_STRAIGHT; cc_c = amps_pkg::CC_LEVEL; end
            4'd5: begin tc_c = amps_pkg::TC_STRAIGHT; cc_c = amps_pkg::CC_UP;    end
            4'd6: begin tc_c = amps_pkg::TC_POS;      cc_c = amps_pkg::CC_DOWN;  end
            4'd7: begin tc_c = amps_pkg::TC_POS;      cc_c = amps_pkg::CC_LEVEL; end
            default: begin tc_c = amps_pkg::TC_POS;   cc_c = amps_pkg::CC_UP;    end
        endcase
        // vanishing turn rate moves straight on
        straight_c = (tc_c == amps_pkg::TC_STRAIGHT) || !w0nz_reg;

        if (tc_c == amps_pkg::TC_POS) begin
            nt_sum = {1'b0, th_c} + {1'b0, wm_reg};
        end else begin
            nt_sum = {1'b0, th_c} + ({1'b0, amps_pkg::TWO_PI_Q} - {1'b0, wm_reg});
        end
        if (nt_sum >= {1'b0, amps_pkg::TWO_PI_Q}) begin
            nt_sum = nt_sum - {1'b0, amps_pkg::TWO_PI_Q};
        end

        sb_in.pos_x    = s_pos_x;
        sb_in.pos_y    = s_pos_y;
        sb_in.pos_z    = s_pos_z;
        sb_in.cost     = s_cost_so_far;
        sb_in.tc       = tc_c;
        sb_in.cc       = cc_c;
        sb_in.nt       = straight_c ? th_c : nt_sum[amps_pkg::ANG_W-1:0];
        sb_in.straight = straight_c;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            th_reg <= th_c;
        end
    end

    // ------------------------------------------------------------------
    // Side band; positions pick up the move at the squaring stage
    // ------------------------------------------------------------------
    logic signed [amps_pkg::D_W-1:0] dx_reg, dy_reg, dz_reg;
    amps_pkg::side_t                 sb_sq_c;

    always_comb begin
        sb_sq_c       = sb_reg[amps_pkg::ST_SQ-1];
        sb_sq_c.pos_x = sb_reg[amps_pkg::ST_SQ-1].pos_x + amps_pkg::POS_W'(dx_reg);
        sb_sq_c.pos_y = sb_reg[amps_pkg::ST_SQ-1].pos_y + amps_pkg::POS_W'(dy_reg);
        sb_sq_c.pos_z = sb_reg[amps_pkg::ST_SQ-1].pos_z + amps_pkg::POS_W'(dz_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[amps_pkg::ST_PREP] <= sb_in;
            for (int i = 1; i <= amps_pkg::ST_OUT; i++) begin
                if (i == amps_pkg::ST_SQ) begin
                    sb_reg[i] <= sb_sq_c;
                end else begin
                    sb_reg[i] <= sb_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Two CORDIC pipelines: old heading (0) and new heading (1)
    // ------------------------------------------------------------------
    logic signed [amps_pkg::XY_W-1:0] x0_reg [0:amps_pkg::CORDIC_N];
    logic signed [amps_pkg::XY_W-1:0] y0_reg [0:amps_pkg::CORDIC_N];
    logic signed [amps_pkg::Z_W-1:0]  z0_reg [0:amps_pkg::CORDIC_N];
    logic                             f0_reg [0:amps_pkg::CORDIC_N];
    logic signed [amps_pkg::XY_W-1:0] x1_reg [0:amps_pkg::CORDIC_N];
    logic signed [amps_pkg::XY_W-1:0] y1_reg [0:amps_pkg::CORDIC_N];
    logic signed [amps_pkg::Z_W-1:0]  z1_reg [0:amps_pkg::CORDIC_N];
    logic                             f1_reg [0:amps_pkg::CORDIC_N];
    amps_pkg::fold_t                  fold0, fold1;

    assign fold0 = amps_pkg::fold_angle(th_reg);
    assign fold1 = amps_pkg::fold_angle(sb_reg[amps_pkg::ST_PREP].nt);

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg[0] <= amps_pkg::GAIN_Q30;
            y0_reg[0] <= '0;
            z0_reg[0] <= fold0.z;
            f0_reg[0] <= fold0.flip;
            x1_reg[0] <= amps_pkg::GAIN_Q30;
            y1_reg[0] <= '0;
            z1_reg[0] <= fold1.z;
            f1_reg[0] <= fold1.flip;
        end
    end

    for (genvar k = 0; k < amps_pkg::CORDIC_N; k++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (en) begin
                if (z0_reg[k] >= 0) begin
                    x0_reg[k+1] <= x0_reg[k] - (y0_reg[k] >>> k);
                    y0_reg[k+1] <= y0_reg[k] + (x0_reg[k] >>> k);
                    z0_reg[k+1] <= z0_reg[k] - amps_pkg::atan_q30(k);
                end else begin
                    x0_reg[k+1] <= x0_reg[k] + (y0_reg[k] >>> k);
                    y0_reg[k+1] <= y0_reg[k] - (x0_reg[k] >>> k);
                    z0_reg[k+1] <= z0_reg[k] + amps_pkg::atan_q30(k);
                end
                if (z1_reg[k] >= 0) begin
                    x1_reg[k+1] <= x1_reg[k] - (y1_reg[k] >>> k);
                    y1_reg[k+1] <= y1_reg[k] + (x1_reg[k] >>> k);
                    z1_reg[k+1] <= z1_reg[k] - amps_pkg::atan_q30(k);
                end else begin
                    x1_reg[k+1] <= x1_reg[k] + (y1_reg[k] >>> k);
                    y1_reg[k+1] <= y1_reg[k] - (x1_reg[k] >>> k);
                    z1_reg[k+1] <= z1_reg[k] + amps_pkg::atan_q30(k);
                end
                f0_reg[k+1] <= f0_reg[k];
                f1_reg[k+1] <= f1_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Operand select, multiply, round
    // ------------------------------------------------------------------
    logic signed [amps_pkg::XY_W-1:0]  c0_c, s0_c, c1_c, s1_c;
    logic [amps_pkg::CFG_W-1:0]        mul_a_c, mul_a_reg;
    logic signed [amps_pkg::Z_W-1:0]   opx_c, opy_c, opx_reg, opy_reg;
    logic signed [amps_pkg::MUL_W-1:0] px_reg, py_reg, rx_c, ry_c;
    logic signed [amps_pkg::D_W-1:0]   dzs_c;
    amps_pkg::side_t                   sb_sel;

    localparam logic signed [amps_pkg::MUL_W-1:0] RND_HALF = amps_pkg::MUL_W'(1) << 29;

    always_comb begin
        sb_sel = sb_reg[amps_pkg::ST_CORDIC_END];
        c0_c = f0_reg[amps_pkg::CORDIC_N] ? -x0_reg[amps_pkg::CORDIC_N]
                                          :  x0_reg[amps_pkg::CORDIC_N];
        s0_c = f0_reg[amps_pkg::CORDIC_N] ? -y0_reg[amps_pkg::CORDIC_N]
                                          :  y0_reg[amps_pkg::CORDIC_N];
        c1_c = f1_reg[amps_pkg::CORDIC_N] ? -x1_reg[amps_pkg::CORDIC_N]
                                          :  x1_reg[amps_pkg::CORDIC_N];
        s1_c = f1_reg[amps_pkg::CORDIC_N] ? -y1_reg[amps_pkg::CORDIC_N]
                                          :  y1_reg[amps_pkg::CORDIC_N];
        if (sb_sel.straight) begin
            mul_a_c = step_reg;
            opx_c   = amps_pkg::Z_W'(c0_c);
            opy_c   = amps_pkg::Z_W'(s0_c);
        end else if (sb_sel.tc == amps_pkg::TC_POS) begin
            // sign folded into the difference so rounding sees the true product
            mul_a_c = rad_eff;
            opx_c   = amps_pkg::Z_W'(s1_c) - amps_pkg::Z_W'(s0_c);
            opy_c   = amps_pkg::Z_W'(c0_c) - amps_pkg::Z_W'(c1_c);
        end else begin
            mul_a_c = rad_eff;
            opx_c   = amps_pkg::Z_W'(s0_c) - amps_pkg::Z_W'(s1_c);
            opy_c   = amps_pkg::Z_W'(c1_c) - amps_pkg::Z_W'(c0_c);
        end

        rx_c = (px_reg + RND_HALF) >>> 30;
        ry_c = (py_reg + RND_HALF) >>> 30;

        unique case (sb_reg[amps_pkg::ST_MUL].cc)
            amps_pkg::CC_DOWN: dzs_c = -$signed(amps_pkg::D_W'(dzq_reg));
            amps_pkg::CC_UP:   dzs_c =  $signed(amps_pkg::D_W'(dzq_reg));
            default:           dzs_c = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mul_a_reg <= mul_a_c;
            opx_reg   <= opx_c;
            opy_reg   <= opy_c;
            px_reg    <= $signed({1'b0, mul_a_reg}) * opx_reg;
            py_reg    <= $signed({1'b0, mul_a_reg}) * opy_reg;
            dx_reg    <= rx_c[amps_pkg::D_W-1:0];
            dy_reg    <= ry_c[amps_pkg::D_W-1:0];
            dz_reg    <= dzs_c;
        end
    end

    // ------------------------------------------------------------------
    // Squares, sum, pipelined square root
    // ------------------------------------------------------------------
    logic signed [amps_pkg::SUM_W-1:0] sqx_c, sqy_c;
    logic [amps_pkg::SUM_W-1:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [amps_pkg::SUM_W-1:0]        sn_reg [0:amps_pkg::SQ_STEPS];
    logic [amps_pkg::SUM_W-1:0]        sr_reg [0:amps_pkg::SQ_STEPS];

    assign sqx_c = dx_reg * dx_reg;
    assign sqy_c = dy_reg * dy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg <= sqx_c;
            sqy_reg <= sqy_c;
            sqz_reg <= (sb_reg[amps_pkg::ST_RND].cc == amps_pkg::CC_LEVEL)
                       ? '0 : amps_pkg::SUM_W'(dzsq_reg);
            sn_reg[0] <= sqx_reg + sqy_reg + sqz_reg;
            sr_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < amps_pkg::SQ_STEPS; j++) begin : g_sqrt
        localparam logic [amps_pkg::SUM_W:0] SQ_BIT =
            (amps_pkg::SUM_W + 1)'(1) << (amps_pkg::SUM_W - 2 - 2 * j);
        logic [amps_pkg::SUM_W:0] trial;

        assign trial = {1'b0, sr_reg[j]} + SQ_BIT;

        always_ff @(posedge aclk) begin
            if (en) begin
                if ({1'b0, sn_reg[j]} >= trial) begin
                    sn_reg[j+1] <= sn_reg[j] - trial[amps_pkg::SUM_W-1:0];
                    sr_reg[j+1] <= (sr_reg[j] >> 1) + SQ_BIT[amps_pkg::SUM_W-1:0];
                end else begin
                    sn_reg[j+1] <= sn_reg[j];
                    sr_reg[j+1] <= sr_reg[j] >> 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: round root to nearest, saturating cost
    // ------------------------------------------------------------------
    logic [amps_pkg::ROOT_W-1:0] len_c;
    logic [amps_pkg::POS_W:0]    cost_sum;
    logic [amps_pkg::POS_W-1:0]  cost_out_reg;

    always_comb begin
        len_c = sr_reg[amps_pkg::SQ_STEPS][amps_pkg::ROOT_W-1:0]
              + amps_pkg::ROOT_W'(sn_reg[amps_pkg::SQ_STEPS] > sr_reg[amps_pkg::SQ_STEPS]);
        cost_sum = {1'b0, sb_reg[amps_pkg::ST_SQRT_END].cost}
                 + (amps_pkg::POS_W + 1)'(len_c);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cost_out_reg <= cost_sum[amps_pkg::POS_W] ? '1
                                                      : cost_sum[amps_pkg::POS_W-1:0];
        end
    end

    assign m_next_x       = sb_reg[amps_pkg::ST_OUT].pos_x;
    assign m_next_y       = sb_reg[amps_pkg::ST_OUT].pos_y;
    assign m_next_z       = sb_reg[amps_pkg::ST_OUT].pos_z;
    assign m_next_heading = sb_reg[amps_pkg::ST_OUT].nt;
    assign m_next_cost    = cost_out_reg;
    assign m_turn_class   = sb_reg[amps_pkg::ST_OUT].tc;

endmodule
